// ===== hw/rtl/mfsg_pkg.sv =====
`timescale 1ns / 1ps

package mfsg_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int WHEELS        = 4;
    localparam int WHEEL_IDX_W   = 2;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int VF_W          = 24;
    localparam int TURN_W        = 16;
    localparam int TMUL_W        = 32;
    localparam int RATE_W        = 16;
    localparam int MIX_W         = 34;
    localparam int MAG_W         = 32;
    localparam int PROD_W        = MAG_W + VF_W;
    localparam int PROD_FRAC     = 28;
    localparam int TMUL_RESET    = 1000000;
    localparam int DIV_CNT_W     = $clog2(TMUL_W);

    localparam logic KIND_VEL  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VEL_FACTOR = 2'd0,
        REG_TURN_PARAM = 2'd1,
        REG_TIME_MULT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] omega;
        logic [31:0]        elapsed_us;
    } cmd_item_t;

    typedef struct packed {
        logic [WHEELS-1:0] step_lines;
        logic [WHEELS-1:0] dir_lines;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_MIX,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic do_tick;
        logic do_mix;
        logic do_mul;
        logic div_start;
        logic div_step;
        logic store_wheel;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic div_last;
        logic last_wheel;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/mfsg_stream_if.sv =====
`timescale 1ns / 1ps

interface mfsg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mfsg_ctrl.sv =====
`timescale 1ns / 1ps

module mfsg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfsg_pkg::dp_stat_t stat,
    output mfsg_pkg::dp_cmd_t  cmds
);
    import mfsg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_pending_reg;
    logic   done_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            done_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            done_pending_reg <= done_pending_next;
        end
    end

    // next state
    always_comb
    begin
        state_next        = state_reg;
        done_pending_next = done_pending_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (done_pending_reg)
                begin
                    if (stat.out_free)
                        done_pending_next = 1'b0;
                end
                else if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.kind == KIND_TICK)
                    state_next = ST_TICK;
                else
                    state_next = ST_MIX;
            end
            ST_TICK:
            begin
                state_next        = ST_IDLE;
                done_pending_next = 1'b1;
            end
            ST_MIX:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (stat.last_wheel)
                begin
                    state_next        = ST_IDLE;
                    done_pending_next = 1'b1;
                end
                else
                begin
                    state_next = ST_MIX;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmds     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = !done_pending_reg;
                cmds.load_in  = !done_pending_reg && in_valid;
                cmds.load_out = done_pending_reg && stat.out_free;
            end
            ST_DECODE:    ;
            ST_TICK:      cmds.do_tick = 1'b1;
            ST_MIX:       cmds.do_mix = 1'b1;
            ST_MUL:       cmds.do_mul = 1'b1;
            ST_DIV_START: cmds.div_start = 1'b1;
            ST_DIV:       cmds.div_step = 1'b1;
            ST_STORE:     cmds.store_wheel = 1'b1;
            default:      ;
        endcase
    end

endmodule

// ===== hw/rtl/mfsg_datapath.sv =====
`timescale 1ns / 1ps

module mfsg_datapath #(
    parameter int TIME_BITS = mfsg_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [mfsg_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [mfsg_pkg::CFG_W-1:0]       wr_data,
    input  mfsg_pkg::cmd_item_t              in_data,
    input  mfsg_pkg::dp_cmd_t                cmds,
    output mfsg_pkg::dp_stat_t               stat,
    output logic                             res_valid,
    input  logic                             res_ready,
    output mfsg_pkg::res_item_t              res_data
);
    import mfsg_pkg::*;

    localparam int PW = TIME_BITS + 1;
    localparam int CW = TIME_BITS + 2;

    logic [VF_W-1:0]   vf_reg;
    logic [TURN_W-1:0] turn_reg;
    logic [TMUL_W-1:0] tmul_reg;

    cmd_item_t in_reg;

    logic signed [PW-1:0] period_reg [WHEELS];
    logic signed [CW-1:0] count_reg  [WHEELS];
    logic [WHEELS-1:0]    step_reg;
    logic [WHEELS-1:0]    dir_reg;

    logic [WHEEL_IDX_W-1:0] wheel_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   fwd_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [RATE_W-1:0]      rem_reg;
    logic [TMUL_W-1:0]      quo_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic      res_valid_reg;
    res_item_t res_data_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg   <= '0;
            turn_reg <= '0;
            tmul_reg <= TMUL_W'(TMUL_RESET);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_VEL_FACTOR: vf_reg   <= wr_data[VF_W-1:0];
                REG_TURN_PARAM: turn_reg <= wr_data[TURN_W-1:0];
                REG_TIME_MULT:  tmul_reg <= wr_data[TMUL_W-1:0];
                default:        ;
            endcase
        end
    end

    // wheel mix
    logic signed [MIX_W-1:0] a_term;
    logic signed [MIX_W-1:0] b_term;
    logic signed [32:0]      r_prod;
    logic signed [MIX_W-1:0] r_term;
    logic signed [MIX_W-1:0] mix;
    logic [MIX_W-1:0]        mix_abs;

    assign a_term  = {{(MIX_W-24){in_reg.vel_x[15]}}, in_reg.vel_x, 8'b0};
    assign b_term  = {{(MIX_W-24){in_reg.vel_y[15]}}, in_reg.vel_y, 8'b0};
    assign r_prod  = $signed({1'b0, turn_reg}) * in_reg.omega;
    assign r_term  = {r_prod[32], r_prod};
    assign mix_abs = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);

    always_comb
    begin
        case (wheel_reg)
            2'd0:    mix = a_term - b_term - r_term;
            2'd1:    mix = a_term + b_term + r_term;
            2'd2:    mix = a_term + b_term - r_term;
            default: mix = a_term - b_term + r_term;
        endcase
    end

    // rate and divider step
    logic [PROD_W-PROD_FRAC-1:0] rate_full;
    logic [RATE_W-1:0]           rate_sat;
    logic [RATE_W:0]             rem_sh;
    logic [RATE_W:0]             rem_diff;
    logic                        quo_bit;
    logic                        quo_ovf;
    logic [TIME_BITS-1:0]        quo_sat;
    logic signed [PW-1:0]        period_new;

    assign rate_full = prod_reg[PROD_W-1:PROD_FRAC];
    assign rate_sat  = (|rate_full[PROD_W-PROD_FRAC-1:RATE_W]) ? '1 : rate_full[RATE_W-1:0];
    assign rem_sh    = {rem_reg, quo_reg[TMUL_W-1]};
    assign rem_diff  = rem_sh - {1'b0, rate_reg};
    assign quo_bit   = rem_sh >= {1'b0, rate_reg};
    assign quo_ovf   = |(quo_reg >> TIME_BITS);
    assign quo_sat   = quo_ovf ? '1 : TIME_BITS'(quo_reg);
    assign period_new = (rate_reg == '0) ? '1 : $signed({1'b0, quo_sat});

    always_ff @(posedge clk)
    begin
        if (cmds.load_in)
            in_reg <= in_data;
        if (cmds.do_mix)
        begin
            mag_reg <= mix_abs[MAG_W-1:0];
            neg_reg <= (mix != '0) && (mix[MIX_W-1] ^ wheel_reg[0]);
        end
        if (cmds.do_mul)
        begin
            prod_reg <= mag_reg * vf_reg;
            fwd_reg  <= !(neg_reg && (vf_reg != '0));
        end
        if (cmds.div_start)
        begin
            rate_reg <= rate_sat;
            rem_reg  <= '0;
            quo_reg  <= tmul_reg;
            cnt_reg  <= '0;
        end
        else if (cmds.div_step)
        begin
            rem_reg <= quo_bit ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            quo_reg <= {quo_reg[TMUL_W-2:0], quo_bit};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // tick lanes
    logic [CW-1:0] dt_ext;
    assign dt_ext = {2'b00, TIME_BITS'(in_reg.elapsed_us)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg <= '0;
            step_reg  <= '0;
            dir_reg   <= '0;
            for (int i = 0; i < WHEELS; i++)
            begin
                period_reg[i] <= '1;
                count_reg[i]  <= '1;
            end
        end
        else
        begin
            if (cmds.store_wheel)
            begin
                period_reg[wheel_reg] <= period_new;
                count_reg[wheel_reg]  <= {period_new[PW-1], period_new};
                dir_reg[wheel_reg]    <= fwd_reg;
                wheel_reg             <= wheel_reg + 1'b1;
            end
            if (cmds.do_tick)
            begin
                for (int i = 0; i < WHEELS; i++)
                begin
                    logic signed [CW-1:0] c;
                    logic signed [CW-1:0] per;
                    c   = count_reg[i] - $signed(dt_ext);
                    per = {period_reg[i][PW-1], period_reg[i]};
                    if (c <= 0)
                    begin
                        step_reg[i]  <= 1'b1;
                        count_reg[i] <= per;
                    end
                    else
                    begin
                        if (c <= (per >>> 1))
                            step_reg[i] <= 1'b0;
                        else if (c <= per)
                            step_reg[i] <= 1'b1;
                        count_reg[i] <= c;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmds.load_out)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmds.load_out)
        begin
            res_data_reg.step_lines <= step_reg;
            res_data_reg.dir_lines  <= dir_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res_data        = res_data_reg;
    assign stat.kind       = in_reg.kind;
    assign stat.div_last   = cnt_reg == DIV_CNT_W'(TMUL_W - 1);
    assign stat.last_wheel = wheel_reg == WHEEL_IDX_W'(WHEELS - 1);
    assign stat.out_free   = !res_valid_reg || res_ready;

endmodule

// ===== hw/rtl/mecanum_four_axis_step_generator.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                                  | handshake
// cmd     | in  | kind, vel_x, vel_y, omega, elapsed_us    | valid/ready
// res     | out | step_lines, dir_lines                    | valid/ready
// cfg     | in  | wr_index, wr_data                        | wr_en
//
// a tick passes through decode and the tick state, then loads the result once the result register is free
// a velocity command runs mix, multiply and the one bit per cycle restoring
// divider once per wheel, then stores that wheel's period and direction
// reset: periods and countdowns at minus one, lines low, time_multiplier 1000000
// a stalled result holds the block once the next item has been taken in and processed

module mecanum_four_axis_step_generator #(
    parameter int TIME_BITS = mfsg_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mfsg_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [mfsg_pkg::CFG_W-1:0]     wr_data,
    mfsg_stream_if.sink                    cmd,
    mfsg_stream_if.source                  res
);
    import mfsg_pkg::*;

    dp_cmd_t  cmds;
    dp_stat_t stat;

    mfsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (stat),
        .cmds     (cmds)
    );

    mfsg_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_data   (cmd.data),
        .cmds      (cmds),
        .stat      (stat),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res_data  (res.data)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("second transfer taken while busy");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(cmds.load_out))
        else $error("result appeared without load");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmds.load_out |-> stat.out_free)
        else $error("result overwritten");

endmodule
